### rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: shared types, character codes and classify logic
// Character constants, the escape-op format passed from the front end to the
// back end through the queue, and the per-byte escape classifier.
// ----------------------------------------------------------------------------
package esc_pkg;

   // Lookahead window: pending bytes plus the byte being classified
   localparam int WIN_DEPTH   = 5;
   localparam int SEQ_DEPTH   = WIN_DEPTH + 1;
   localparam int FILL_WIDTH  = $clog2(SEQ_DEPTH + 1);

   // Op queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Character codes
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LC_N  = 8'h6e;
   localparam logic [7:0] CH_LC_R  = 8'h72;
   localparam logic [7:0] CH_LC_B  = 8'h62;
   localparam logic [7:0] CH_LC_T  = 8'h74;
   localparam logic [7:0] CH_LC_U  = 8'h75;
   localparam logic [7:0] CH_LC_X  = 8'h78;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_7     = 8'h37;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LC_A  = 8'h61;
   localparam logic [7:0] CH_LC_F  = 8'h66;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_F  = 8'h46;

   // Window contents, index 0 is the oldest byte
   typedef logic [SEQ_DEPTH-1:0][7:0] seq_type;

   // One escape op: pair emits a backslash and then data, else data alone
   typedef struct packed {
      logic       pair;
      logic [7:0] data;
      logic       run_end;
      logic       string_end;
   } op_type;

   // Queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CH_0 && c <= CH_9) || (c >= CH_LC_A && c <= CH_LC_F) ||
             (c >= CH_UC_A && c <= CH_UC_F);
   endfunction

   function automatic logic is_oct(input logic [7:0] c);
      return c >= CH_0 && c <= CH_7;
   endfunction

   // Classify s[0]; follow says how many of s[1..] are real bytes
   function automatic op_type classify(input seq_type s,
                                       input logic [FILL_WIDTH-1:0] follow);
      op_type op;
      logic   u_ok;
      logic   x_ok;
      logic   o_ok;
      u_ok = (follow >= FILL_WIDTH'(5)) && (s[1] == CH_LC_U) && is_hex(s[2]) &&
             is_hex(s[3]) && is_hex(s[4]) && is_hex(s[5]);
      x_ok = (follow >= FILL_WIDTH'(3)) && (s[1] == CH_LC_X) && is_hex(s[2]) &&
             is_hex(s[3]);
      o_ok = (follow >= FILL_WIDTH'(3)) && is_oct(s[1]);
      op.run_end    = 1'b0;
      op.string_end = 1'b0;
      unique case (s[0])
         CH_NL: begin
            op.pair = 1'b1;
            op.data = CH_LC_N;
         end
         CH_CR: begin
            op.pair = 1'b1;
            op.data = CH_LC_R;
         end
         CH_BS: begin
            op.pair = 1'b1;
            op.data = CH_LC_B;
         end
         CH_TAB: begin
            op.pair = 1'b1;
            op.data = CH_LC_T;
         end
         CH_QUOTE: begin
            op.pair = 1'b1;
            op.data = CH_QUOTE;
         end
         CH_BSL: begin
            // single when it opens a sequence, doubled otherwise
            op.pair = !(u_ok || x_ok || o_ok);
            op.data = CH_BSL;
         end
         default: begin
            op.pair = 1'b0;
            op.data = s[0];
         end
      endcase
      return op;
   endfunction

endpackage

### rtl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front: request intake and lookahead classifier
// Holds the five-byte lookahead window, classifies its oldest byte once full,
// and at string end flushes it all, one op a cycle while the queue has room.
// ----------------------------------------------------------------------------
module esc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic                      req_tlast,
   input  esc_pkg::queue_status_type q_status,
   output logic                      push_valid,
   output esc_pkg::op_type           push_op
);
   import esc_pkg::*;

   seq_type               buf_ff,   buf_in;
   logic [FILL_WIDTH-1:0] fill_ff,  fill_in;
   logic                  flush_ff, flush_in;

   logic                  accept;
   logic                  slide;
   logic                  flush_step;
   seq_type               seq;
   logic [FILL_WIDTH-1:0] follow;
   op_type                op;

   assign req_tready = !flush_ff && !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign slide      = accept && !req_tlast && (fill_ff == FILL_WIDTH'(WIN_DEPTH));
   assign flush_step = flush_ff && !q_status.full;

   // Classify: full window plus new byte, or the buffer during a flush
   always_comb begin
      seq = buf_ff;
      if (!flush_ff) begin
         seq[WIN_DEPTH] = req_tdata;
      end
      follow = flush_ff ? (fill_ff - FILL_WIDTH'(1)) : FILL_WIDTH'(WIN_DEPTH);
      op     = classify(seq, follow);
      if (flush_ff) begin
         op.run_end    = (fill_ff == FILL_WIDTH'(1));
         op.string_end = (fill_ff == FILL_WIDTH'(1));
      end else begin
         op.run_end    = 1'b1;
         op.string_end = 1'b0;
      end
   end

   assign push_valid = slide || flush_step;
   assign push_op    = op;

   // Window update
   always_comb begin
      buf_in   = buf_ff;
      fill_in  = fill_ff;
      flush_in = flush_ff;
      if (slide) begin
         for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         buf_in[WIN_DEPTH-1] = req_tdata;
      end else if (accept) begin
         buf_in[fill_ff] = req_tdata;
         fill_in         = fill_ff + FILL_WIDTH'(1);
         flush_in        = req_tlast;
      end else if (flush_step) begin
         for (int i = 0; i < SEQ_DEPTH - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         fill_in = fill_ff - FILL_WIDTH'(1);
         if (fill_ff == FILL_WIDTH'(1)) begin
            flush_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         fill_ff  <= '0;
         flush_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         flush_ff <= flush_in;
      end
   end

endmodule

### rtl/esc_queue.sv
// ----------------------------------------------------------------------------
// esc_queue: op queue between front and back end
// Small register FIFO of escape ops; head entry is visible without a pop.
// ----------------------------------------------------------------------------
module esc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  esc_pkg::op_type           push_op,
   input  logic                      pop,
   output esc_pkg::op_type           head_op,
   output esc_pkg::queue_status_type q_status
);
   import esc_pkg::*;

   op_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff,  count_in;

   logic do_push;
   logic do_pop;

   assign q_status.full  = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push_valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_op        = entry_ff[rd_ptr_ff];

   // Pointer and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back: op expander and response output register
// Pops escape ops and emits one or two bytes each through a registered
// response stage; the run and string end flags ride on the final byte.
// ----------------------------------------------------------------------------
module esc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  esc_pkg::op_type           head_op,
   input  esc_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      rsp_tuser
);
   import esc_pkg::*;

   logic       valid_ff,  valid_in;
   logic [7:0] data_ff,   data_in;
   logic       last_ff,   last_in;
   logic       user_ff,   user_in;
   logic       second_ff, second_in;
   op_type     pend_ff,   pend_in;

   logic load;

   assign load = !valid_ff || rsp_tready;
   assign pop  = load && !second_ff && !q_status.empty;

   // Next output byte: second half of a pair, else the queue head
   always_comb begin
      valid_in  = valid_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      user_in   = user_ff;
      second_in = second_ff;
      pend_in   = pend_ff;
      if (load) begin
         if (second_ff) begin
            valid_in  = 1'b1;
            data_in   = pend_ff.data;
            last_in   = pend_ff.run_end;
            user_in   = pend_ff.string_end;
            second_in = 1'b0;
         end else if (!q_status.empty) begin
            valid_in = 1'b1;
            if (head_op.pair) begin
               data_in   = CH_BSL;
               last_in   = 1'b0;
               user_in   = 1'b0;
               second_in = 1'b1;
               pend_in   = head_op;
            end else begin
               data_in = head_op.data;
               last_in = head_op.run_end;
               user_in = head_op.string_end;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      user_ff <= user_in;
      pend_ff <= pend_in;
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

### rtl/string_escape_encoder_core.sv
// ----------------------------------------------------------------------------
// string_escape_encoder_core: C string literal escape encoder
// Request stream carries raw string bytes with tlast on the final byte.
// Response stream carries the escaped bytes: tlast marks the final byte
// produced by one request, tuser marks the final byte of the string.
// The first five bytes of a string are held as lookahead and give no
// response; each later byte releases the oldest pending byte as one or two
// response bytes. A request with tlast flushes the window, one pending byte
// per cycle while the op queue has room, and blocks further requests until
// the flush ends. The releasing request's op passes through the queue and
// then the output register before its first response byte. Responses move one
// byte a cycle while the receiver is ready: one request per cycle for plain
// bytes, while bytes that escape to two hold intake back to the output pace.
// A four-entry op queue separates intake from output: requests keep being
// taken while the receiver stalls until that queue fills, then tready drops.
// Reset empties the window, the queue and the output register.
// ----------------------------------------------------------------------------
module string_escape_encoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,
   output logic       rsp_tuser    // [0] string_end
);
   import esc_pkg::*;

   queue_status_type q_status;
   logic             push_valid;
   op_type           push_op;
   logic             pop;
   op_type           head_op;

   esc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_op    (push_op)
   );

   esc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .pop        (pop),
      .head_op    (head_op),
      .q_status   (q_status)
   );

   esc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_op    (head_op),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker: port-level checks for the escape encoder
// Watches the top-level streams and flags output and flush misbehavior.
// ----------------------------------------------------------------------------
module esc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // Stalled response holds its byte and flags
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // String end is always also the end of its run
   a_end_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("string end without run end");

   // Output register is empty after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // Final request starts a flush that blocks the next request
   a_flush_block: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("request taken during window flush");

endmodule

bind string_escape_encoder_core esc_checker u_esc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

### tb/string_escape_encoder_core_tb.sv
// ----------------------------------------------------------------------------
// string_escape_encoder_core_tb: self-checking bench for the escape encoder
// Sends strings one byte per request, predicts the escaped byte stream with a
// local lookahead-window model and checks every response byte, its per-request
// end flag and its end-of-string flag in order. Both stream sides idle at
// random, the receiver holds off once long enough to back the block up, and
// the sender waits at times for the response stream to run dry.
// ----------------------------------------------------------------------------
module string_escape_encoder_core_tb;
   import esc_pkg::*;

   localparam int         WINDOW     = 5;
   localparam int         IDLE_LIMIT = 1000;
   localparam int         RANDOM_REQ = 84;
   localparam int         LONG_HOLD  = 80;
   localparam logic [7:0] PRINT_LO   = 8'h20;
   localparam logic [7:0] PRINT_HI   = 8'h7e;

   // One pending request and the idle cycles that come before it
   typedef struct {
      logic [7:0]  in_byte;
      logic        in_last;
      int unsigned gap;
      bit          drain;
   } raw_byte_type;

   // One expected response byte
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       string_end;
   } escaped_byte_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_byte
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic       rsp_tlast;
   logic       rsp_tuser;            // [0] string_end

   raw_byte_type     raw_pending[$];
   escaped_byte_type escaped_expected[$];

   // Lookahead window of the predictor, oldest byte first
   logic [7:0] window_q [0:WINDOW-1];
   int         window_cnt;

   int          error_count   = 0;
   int          escaped_seen  = 0;
   int          idle_cycles   = 0;
   bit          req_taken     = 1'b0;
   int unsigned req_gap_left  = 0;
   bit          string_calm   = 1'b0;
   bit          drain_next    = 1'b0;
   int          rx_hold_left  = 0;
   bit          long_hold_done = 1'b0;
   int          rx_cycle      = 0;

   string_escape_encoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic bit hex_digit(input logic [7:0] c);
      return (c >= CH_0 && c <= CH_9) || (c >= CH_LC_A && c <= CH_LC_F) ||
             (c >= CH_UC_A && c <= CH_UC_F);
   endfunction

   function automatic bit octal_digit(input logic [7:0] c);
      return c >= CH_0 && c <= CH_7;
   endfunction

   // Escaped form of s[pos] with 'follow' known bytes after it; returns 1 or 2
   function automatic int escape_byte(input logic [7:0] s [0:WINDOW], input int pos,
                                      input int follow, output logic [7:0] e0,
                                      output logic [7:0] e1);
      bit opens_seq;
      opens_seq = 1'b0;
      e0 = CH_BSL;
      e1 = 8'h00;
      case (s[pos])
         CH_NL:    e1 = CH_LC_N;
         CH_CR:    e1 = CH_LC_R;
         CH_BS:    e1 = CH_LC_B;
         CH_TAB:   e1 = CH_LC_T;
         CH_QUOTE: e1 = CH_QUOTE;
         CH_BSL: begin
            if (follow >= 5 && s[pos+1] == CH_LC_U && hex_digit(s[pos+2]) &&
                hex_digit(s[pos+3]) && hex_digit(s[pos+4]) && hex_digit(s[pos+5]))
               opens_seq = 1'b1;
            else if (follow >= 3 && s[pos+1] == CH_LC_X && hex_digit(s[pos+2]) &&
                     hex_digit(s[pos+3]))
               opens_seq = 1'b1;
            else if (follow >= 3 && octal_digit(s[pos+1]))
               opens_seq = 1'b1;
            if (opens_seq)
               return 1;
            e1 = CH_BSL;
         end
         default: begin
            e0 = s[pos];
            return 1;
         end
      endcase
      return 2;
   endfunction

   // Advance the window by one request and queue the bytes it releases
   task automatic predict_escape(input logic [7:0] b, input logic last);
      logic [7:0]       seq [0:WINDOW];
      logic [7:0]       out_q[$];
      logic [7:0]       e0;
      logic [7:0]       e1;
      int               n;
      int               cnt;
      escaped_byte_type r;
      for (int i = 0; i <= WINDOW; i++)
         seq[i] = (i < WINDOW) ? window_q[i] : 8'h00;
      seq[window_cnt] = b;
      n = window_cnt + 1;
      if (last) begin
         for (int p = 0; p < n; p++) begin
            cnt = escape_byte(seq, p, n - 1 - p, e0, e1);
            out_q.push_back(e0);
            if (cnt == 2)
               out_q.push_back(e1);
         end
         window_cnt = 0;
      end else if (n <= WINDOW) begin
         window_q[window_cnt] = b;
         window_cnt = n;
      end else begin
         cnt = escape_byte(seq, 0, WINDOW, e0, e1);
         out_q.push_back(e0);
         if (cnt == 2)
            out_q.push_back(e1);
         for (int i = 0; i < WINDOW; i++)
            window_q[i] = seq[i+1];
      end
      foreach (out_q[k]) begin
         r.out_byte   = out_q[k];
         r.run_end    = (k == out_q.size() - 1);
         r.string_end = last && (k == out_q.size() - 1);
         escaped_expected.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------- stimulus
   task automatic push_request(input logic [7:0] b, input logic last);
      raw_byte_type item;
      int           r;
      r = $urandom_range(0, 99);
      item.in_byte = b;
      item.in_last = last;
      item.drain   = drain_next;
      if (string_calm || r < 60)
         item.gap = 0;
      else if (r < 90)
         item.gap = $urandom_range(1, 3);
      else
         item.gap = $urandom_range(8, 30);
      drain_next = 1'b0;
      raw_pending.push_back(item);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_request(s[i], 1'b0);
   endtask

   function automatic logic [7:0] rand_hex();
      case ($urandom_range(0, 2))
         0:       return 8'($urandom_range(CH_0, CH_9));
         1:       return 8'($urandom_range(CH_LC_A, CH_LC_F));
         default: return 8'($urandom_range(CH_UC_A, CH_UC_F));
      endcase
   endfunction

   function automatic logic [7:0] rand_special();
      case ($urandom_range(0, 5))
         0:       return CH_NL;
         1:       return CH_CR;
         2:       return CH_BS;
         3:       return CH_TAB;
         4:       return CH_QUOTE;
         default: return CH_BSL;
      endcase
   endfunction

   // Mostly well-formed escape sequences with random digits, cut at a random
   // length so sequences also break at the string end
   task automatic push_random_string(output int count);
      logic [7:0] s[$];
      int         len;
      int         r;
      int         digits;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      while (s.size() < len) begin
         r = $urandom_range(0, 99);
         if (r < 25) begin
            s.push_back(CH_BSL);
            s.push_back(CH_LC_U);
            for (int i = 0; i < 4; i++)
               s.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : rand_hex());
         end else if (r < 40) begin
            s.push_back(CH_BSL);
            s.push_back(CH_LC_X);
            s.push_back(rand_hex());
            s.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : rand_hex());
         end else if (r < 55) begin
            s.push_back(CH_BSL);
            digits = $urandom_range(1, 3);
            for (int i = 0; i < digits; i++)
               s.push_back(8'($urandom_range(CH_0, CH_7)));
         end else if (r < 70)
            s.push_back(rand_special());
         else if (r < 85)
            s.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
         else
            s.push_back(8'($urandom));
      end
      string_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++)
         push_request(s[i], i == len - 1);
      count = len;
   endtask

   // ---------------------------------------------------------------- sender
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (req_gap_left > 0) begin
               req_gap_left <= req_gap_left - 1;
               req_tvalid   <= 1'b0;
            end else if (raw_pending.size() == 0 ||
                         (raw_pending[0].drain && escaped_expected.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tdata  <= raw_pending[0].in_byte;
               req_tlast  <= raw_pending[0].in_last;
               req_tvalid <= 1'b1;
               void'(raw_pending.pop_front());
               req_gap_left <= (raw_pending.size() != 0) ? raw_pending[0].gap : 0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   // calm stretches, short random holds, and one long hold to fill the block
   always @(negedge clock) begin
      int r;
      if (!reset) begin
         rx_cycle = rx_cycle + 1;
         r = $urandom_range(0, 99);
         if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && escaped_seen >= 30) begin
            long_hold_done = 1'b1;
            rx_hold_left   = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if ((rx_cycle % 300) < 80 || r >= 20) begin
            rsp_tready <= 1'b1;
         end else begin
            rx_hold_left = (r < 3) ? $urandom_range(8, 30) : $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      escaped_byte_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_escape(req_tdata, req_tlast);
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            escaped_seen = escaped_seen + 1;
            if (escaped_expected.size() == 0) begin
               $error("response with nothing expected: out_byte %h", rsp_tdata);
               error_count++;
            end else begin
               want = escaped_expected.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  $error("out_byte expected %h actual %h", want.out_byte, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== want.run_end) begin
                  $error("run_end expected %b actual %b", want.run_end, rsp_tlast);
                  error_count++;
               end
               if (rsp_tuser !== want.string_end) begin
                  $error("string_end expected %b actual %b", want.string_end, rsp_tuser);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      int total;
      int cnt;
      for (int i = 0; i < WINDOW; i++)
         window_q[i] = 8'h00;
      window_cnt = 0;

      // single-byte string with every bit set
      push_request(8'hff, 1'b1);
      // unicode, hex and one-digit octal openers, every escaped control byte,
      // then a zero byte closing the string
      push_text("\\u0aF9\\x4b\\7");
      push_request(CH_NL, 1'b0);
      push_request(CH_CR, 1'b0);
      push_request(CH_BS, 1'b0);
      push_request(CH_TAB, 1'b0);
      push_request(CH_QUOTE, 1'b0);
      push_request(8'h00, 1'b1);
      // hex opener cut short by a high byte at the string end
      drain_next = 1'b1;
      push_text("\\x4");
      push_request(8'h80, 1'b1);

      total = 0;
      drain_next = 1'b1;
      while (total < RANDOM_REQ) begin
         if ($urandom_range(0, 9) == 0)
            drain_next = 1'b1;
         push_random_string(cnt);
         total += cnt;
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (raw_pending.size() != 0 || req_tvalid)
         @(posedge clock);
      while (escaped_expected.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0 && escaped_expected.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
